// ===== rtl/earc_pkg.sv =====
// shared types, constants and helpers for the elevon attitude-rate controller
package earc_pkg;

    localparam int FRAC_BITS = 12;
    localparam int LOOP_FRAC = 16;
    localparam int EST_SHIFT = FRAC_BITS + LOOP_FRAC;

    localparam int DATA_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int CMD_W   = 14;
    localparam int MOT_W   = 13;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 16;
    localparam int EST_W   = 32;
    localparam int MCAND_W = EST_W + 1;
    localparam int PROD_W  = MCAND_W + 1 + GAIN_W;
    localparam int ACC_W   = 34;
    localparam int U_W     = 22;
    localparam int ERR_W   = 18;
    localparam int CLAMP_W = 24;

    localparam int ONE_Q    = 1 << FRAC_BITS;
    localparam int RATE_LIM = 2 * ONE_Q;
    localparam int YAW_LIM  = ONE_Q / 4;
    localparam int HOLD_LIM = (3 * ONE_Q + 5) / 10;

    localparam logic [GAIN_W-1:0] RST_ATT_GAIN  = GAIN_W'(4096);
    localparam logic [GAIN_W-1:0] RST_RATE_GAIN = GAIN_W'(4096);
    localparam logic [GAIN_W-1:0] RST_DAMP_GAIN = GAIN_W'(0);
    localparam logic [GAIN_W-1:0] RST_YAW_GAIN  = GAIN_W'(4096);
    localparam logic [MOT_W-1:0]  RST_IDLE      = MOT_W'(0);
    localparam logic [GAIN_W-1:0] RST_PERIOD    = GAIN_W'(66);

    typedef enum logic [IDX_W-1:0] {
        CFG_ATT_GAIN  = 3'd0,
        CFG_RATE_GAIN = 3'd1,
        CFG_DAMP_GAIN = 3'd2,
        CFG_YAW_GAIN  = 3'd3,
        CFG_IDLE      = 3'd4,
        CFG_PERIOD    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] attitude_gain;
        logic [GAIN_W-1:0] rate_gain;
        logic [GAIN_W-1:0] damping_gain;
        logic [GAIN_W-1:0] yaw_gain;
        logic [MOT_W-1:0]  idle_level;
        logic [GAIN_W-1:0] loop_period;
    } cfg_t;

    // saturate a signed value to [lo, hi]
    function automatic logic signed [CLAMP_W-1:0] clamp(
        input logic signed [CLAMP_W-1:0] v,
        input int lo,
        input int hi
    );
        logic signed [CLAMP_W-1:0] r;
        if (v < lo)
            r = CLAMP_W'(lo);
        else if (v > hi)
            r = CLAMP_W'(hi);
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== rtl/earc_if.sv =====
// handshake channel interfaces: input sample, result, configuration write
interface earc_in_if;
    import earc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     setpoint_valid;
    logic signed [DATA_W-1:0] roll_setpoint;
    logic signed [DATA_W-1:0] pitch_setpoint;
    logic signed [DATA_W-1:0] yaw_rate_setpoint;
    logic signed [DATA_W-1:0] thrust_setpoint;
    logic signed [DATA_W-1:0] gyro_x;
    logic signed [DATA_W-1:0] gyro_y;
    logic signed [DATA_W-1:0] gyro_z;
    logic                     hold_request;

    modport source (
        output valid, setpoint_valid, roll_setpoint, pitch_setpoint, yaw_rate_setpoint,
               thrust_setpoint, gyro_x, gyro_y, gyro_z, hold_request,
        input  ready
    );
    modport sink (
        input  valid, setpoint_valid, roll_setpoint, pitch_setpoint, yaw_rate_setpoint,
               thrust_setpoint, gyro_x, gyro_y, gyro_z, hold_request,
        output ready
    );
endinterface

interface earc_out_if;
    import earc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [CMD_W-1:0] left_elevon;
    logic signed [CMD_W-1:0] right_elevon;
    logic [MOT_W-1:0]        motor_left;
    logic [MOT_W-1:0]        motor_right;

    modport source (
        output valid, left_elevon, right_elevon, motor_left, motor_right,
        input  ready
    );
    modport sink (
        input  valid, left_elevon, right_elevon, motor_left, motor_right,
        output ready
    );
endinterface

interface earc_cfg_if;
    import earc_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/earc_smul.sv =====
// bit-serial signed by unsigned shift-add multiplier, one multiplier bit per cycle
module earc_smul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [earc_pkg::MCAND_W-1:0] mcand,
    input  logic [earc_pkg::GAIN_W-1:0]         mplier,
    output logic                                done,
    output logic signed [earc_pkg::PROD_W-1:0]  product
);
    import earc_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);

    logic signed [MCAND_W-1:0] mcand_reg;
    logic signed [MCAND_W:0]   hi_reg;
    logic signed [MCAND_W:0]   hi_next;
    logic signed [MCAND_W:0]   sum;
    logic signed [MCAND_W:0]   addend;
    logic [GAIN_W-1:0]         lo_reg;
    logic [GAIN_W-1:0]         lo_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    // low half doubles as the multiplier shift register
    always_comb
    begin
        addend  = lo_reg[0] ? (MCAND_W + 1)'(mcand_reg) : '0;
        sum     = hi_reg + addend;
        hi_next = sum >>> 1;
        lo_next = {sum[0], lo_reg[GAIN_W-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg + 1'b1;
            done_reg <= (cnt_reg == CNT_W'(GAIN_W - 1));
            busy_reg <= (cnt_reg != CNT_W'(GAIN_W - 1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= mcand;
            hi_reg    <= '0;
            lo_reg    <= mplier;
        end
        else if (busy_reg)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// ===== rtl/earc_axis.sv =====
// one roll or pitch axis: angle estimate, angle loop and rate loop on a serial multiplier
module earc_axis (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               hold,
    input  earc_pkg::cfg_t                     cfg,
    input  logic signed [earc_pkg::DATA_W-1:0] setpoint,
    input  logic signed [earc_pkg::DATA_W-1:0] rate,
    output logic                               done,
    output logic signed [earc_pkg::U_W-1:0]    u
);
    import earc_pkg::*;

    typedef enum logic [2:0] {
        AX_IDLE,
        AX_ATT,
        AX_EST,
        AX_RATE,
        AX_DAMP
    } ax_state_t;

    ax_state_t                 state_reg;
    logic signed [EST_W-1:0]   est_reg;
    logic signed [DATA_W-1:0]  rc_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [U_W-1:0]     u_reg;
    logic                      done_reg;

    logic                      mul_start;
    logic                      mul_done;
    logic signed [MCAND_W-1:0] mcand;
    logic [GAIN_W-1:0]         mplier;
    logic signed [PROD_W-1:0]  product;

    logic signed [MCAND_W-1:0] sp_scaled;
    logic signed [MCAND_W-1:0] angle_err;
    logic signed [PROD_W-1:0]  att_full;
    logic signed [U_W-1:0]     att_sh;
    logic signed [CLAMP_W-1:0] rc_lim;
    logic signed [EST_W:0]     est_sum;
    logic signed [EST_W-1:0]   est_sat;
    logic signed [ERR_W-1:0]   rate_err;
    logic signed [ACC_W-1:0]   fin;
    logic signed [ACC_W-1:0]   fin_sh;

    always_comb
    begin
        // error uses the estimate from before this sample
        sp_scaled = MCAND_W'(setpoint) <<< LOOP_FRAC;
        angle_err = sp_scaled - MCAND_W'(est_reg);

        att_full = product >>> EST_SHIFT;
        att_sh   = $signed(att_full[U_W-1:0]);
        rc_lim   = clamp(CLAMP_W'(att_sh), -RATE_LIM, RATE_LIM);

        est_sum = (EST_W + 1)'(est_reg) + $signed(product[EST_W:0]);
        if (est_sum[EST_W] != est_sum[EST_W-1])
            est_sat = est_sum[EST_W] ? {1'b1, {(EST_W-1){1'b0}}} : {1'b0, {(EST_W-1){1'b1}}};
        else
            est_sat = est_sum[EST_W-1:0];

        rate_err = ERR_W'(rc_reg) - ERR_W'(rate);

        fin    = acc_reg - $signed(product[ACC_W-1:0]);
        fin_sh = fin >>> FRAC_BITS;

        case (state_reg)
            AX_IDLE:
            begin
                mcand  = angle_err;
                mplier = cfg.attitude_gain;
            end
            AX_ATT:
            begin
                mcand  = MCAND_W'(rate);
                mplier = cfg.loop_period;
            end
            AX_EST:
            begin
                mcand  = MCAND_W'(rate_err);
                mplier = cfg.rate_gain;
            end
            AX_RATE:
            begin
                mcand  = MCAND_W'(rate);
                mplier = hold ? '0 : cfg.damping_gain;
            end
            default:
            begin
                mcand  = '0;
                mplier = '0;
            end
        endcase

        mul_start = ((state_reg == AX_IDLE) && start) ||
                    (((state_reg == AX_ATT) || (state_reg == AX_EST) ||
                      (state_reg == AX_RATE)) && mul_done);
    end

    earc_smul u_smul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mcand),
        .mplier  (mplier),
        .done    (mul_done),
        .product (product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AX_IDLE;
            est_reg   <= '0;
            rc_reg    <= '0;
            acc_reg   <= '0;
            u_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                AX_IDLE:
                begin
                    if (start)
                        state_reg <= AX_ATT;
                end
                AX_ATT:
                begin
                    if (mul_done)
                    begin
                        // hold mode drops the angle loop
                        rc_reg    <= hold ? '0 : DATA_W'(rc_lim);
                        state_reg <= AX_EST;
                    end
                end
                AX_EST:
                begin
                    if (mul_done)
                    begin
                        est_reg   <= est_sat;
                        state_reg <= AX_RATE;
                    end
                end
                AX_RATE:
                begin
                    if (mul_done)
                    begin
                        acc_reg   <= $signed(product[ACC_W-1:0]);
                        state_reg <= AX_DAMP;
                    end
                end
                AX_DAMP:
                begin
                    if (mul_done)
                    begin
                        u_reg     <= $signed(fin_sh[U_W-1:0]);
                        done_reg  <= 1'b1;
                        state_reg <= AX_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= AX_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign u    = u_reg;

endmodule

// ===== rtl/elevon_attitude_rate_controller.sv =====
// top level: setpoint latch, hold logic, roll/pitch/yaw loops and elevon mixer
//
//  channel  dir   handshake          payload
//  in_ch    in    valid/ready        setpoint_valid, 4 setpoints, gyro_x/y/z, hold_request
//  out_ch   out   valid/ready        left_elevon/right_elevon, motor_left/right
//  cfg_ch   in    valid/ready        index, data
//
//  one transaction at a time: the next sample can be accepted only after the result is registered
//  each axis runs four serial multiplies back to back (angle, estimate, rate, damping),
//  each a load plus 16 shift-add steps, then the top collects the done flags and registers the result
//  yaw uses a third serial multiplier in parallel with the axes
//  a finished result sits in the output register; a new sample is taken while it waits,
//  and its result then waits until the register frees, holding off the input
//  reset restores the gains and clears setpoints, hold mode and estimates; both inputs
//  are ready from the first clock edge after reset release
module elevon_attitude_rate_controller (
    input  logic      clk,
    input  logic      rst_n,
    earc_in_if.sink   in_ch,
    earc_out_if.source out_ch,
    earc_cfg_if.sink  cfg_ch
);
    import earc_pkg::*;

    typedef enum logic [1:0] {
        T_IDLE,
        T_START,
        T_RUN,
        T_FIN
    } top_state_t;

    top_state_t                state_reg;
    cfg_t                      cfg_reg;
    logic                      live_reg;

    // latched setpoint and hold flag
    logic signed [DATA_W-1:0]  held_roll_reg;
    logic signed [DATA_W-1:0]  held_pitch_reg;
    logic signed [DATA_W-1:0]  held_yaw_reg;
    logic signed [DATA_W-1:0]  held_thrust_reg;
    logic                      hold_reg;

    // gyro sample of the transaction in flight
    logic signed [DATA_W-1:0]  gx_reg;
    logic signed [DATA_W-1:0]  gy_reg;
    logic signed [DATA_W-1:0]  gz_reg;

    logic                      roll_seen_reg;
    logic                      pitch_seen_reg;
    logic                      yaw_seen_reg;
    logic signed [U_W-1:0]     yaw_u_reg;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [CMD_W-1:0]   el_reg;
    logic signed [CMD_W-1:0]   er_reg;
    logic [MOT_W-1:0]          ml_reg;
    logic [MOT_W-1:0]          mr_reg;

    logic                      in_accept;
    logic                      go;
    logic                      roll_done;
    logic                      pitch_done;
    logic                      yaw_done;
    logic signed [U_W-1:0]     roll_u;
    logic signed [U_W-1:0]     pitch_u;

    logic signed [DATA_W:0]    yaw_err;
    logic signed [PROD_W-1:0]  yaw_prod;
    logic signed [PROD_W-1:0]  yaw_sh;

    logic signed [CLAMP_W-1:0] sum_lr;
    logic signed [CLAMP_W-1:0] dif_lr;
    logic signed [CLAMP_W-1:0] yaw_mix;
    logic signed [CLAMP_W-1:0] thr;
    logic signed [CLAMP_W-1:0] idle_ext;
    logic signed [CLAMP_W-1:0] el_c;
    logic signed [CLAMP_W-1:0] er_c;
    logic signed [CLAMP_W-1:0] ml_c;
    logic signed [CLAMP_W-1:0] mr_c;
    logic                      all_done;
    logic                      out_free;

    // nothing is taken while reset is held
    assign in_accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = live_reg && (state_reg == T_IDLE);
    assign cfg_ch.ready = live_reg;
    assign go = (state_reg == T_START);

    // yaw loop: rate error times yaw gain
    assign yaw_err = (DATA_W + 1)'(held_yaw_reg) - (DATA_W + 1)'(gz_reg);
    assign yaw_sh  = yaw_prod >>> FRAC_BITS;

    earc_smul u_yaw_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (go),
        .mcand   (MCAND_W'(yaw_err)),
        .mplier  (cfg_reg.yaw_gain),
        .done    (yaw_done),
        .product (yaw_prod)
    );

    earc_axis u_roll (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (go),
        .hold     (hold_reg),
        .cfg      (cfg_reg),
        .setpoint (held_roll_reg),
        .rate     (gx_reg),
        .done     (roll_done),
        .u        (roll_u)
    );

    earc_axis u_pitch (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (go),
        .hold     (hold_reg),
        .cfg      (cfg_reg),
        .setpoint (held_pitch_reg),
        .rate     (gy_reg),
        .done     (pitch_done),
        .u        (pitch_u)
    );

    // elevon and motor mixing
    always_comb
    begin
        sum_lr   = CLAMP_W'(pitch_u) + CLAMP_W'(roll_u);
        dif_lr   = CLAMP_W'(pitch_u) - CLAMP_W'(roll_u);
        yaw_mix  = clamp(CLAMP_W'(yaw_u_reg), -YAW_LIM, YAW_LIM);
        thr      = clamp(CLAMP_W'(held_thrust_reg), 0, ONE_Q);
        idle_ext = CLAMP_W'(cfg_reg.idle_level);
        if (hold_reg)
        begin
            // hold: pure rate damping, motors at idle
            el_c = clamp(CLAMP_W'(roll_u), -HOLD_LIM, HOLD_LIM);
            er_c = clamp(CLAMP_W'(pitch_u), -HOLD_LIM, HOLD_LIM);
            ml_c = clamp(idle_ext, 0, ONE_Q);
            mr_c = ml_c;
        end
        else
        begin
            el_c = clamp(sum_lr, -ONE_Q, ONE_Q);
            er_c = clamp(dif_lr, -ONE_Q, ONE_Q);
            ml_c = clamp(thr - yaw_mix, 0, ONE_Q);
            mr_c = clamp(thr + yaw_mix, 0, ONE_Q);
        end
        all_done = (roll_seen_reg || roll_done) && (pitch_seen_reg || pitch_done) &&
                   (yaw_seen_reg || yaw_done);
        out_free = !out_valid_reg || out_ch.ready;
        // a new result replaces the one leaving in the same cycle
        out_valid_next = ((state_reg == T_FIN) && out_free) ||
                         (out_valid_reg && !out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= T_IDLE;
            live_reg        <= 1'b0;
            cfg_reg         <= '{attitude_gain: RST_ATT_GAIN, rate_gain: RST_RATE_GAIN,
                                 damping_gain: RST_DAMP_GAIN, yaw_gain: RST_YAW_GAIN,
                                 idle_level: RST_IDLE, loop_period: RST_PERIOD};
            held_roll_reg   <= '0;
            held_pitch_reg  <= '0;
            held_yaw_reg    <= '0;
            held_thrust_reg <= '0;
            hold_reg        <= 1'b0;
            roll_seen_reg   <= 1'b0;
            pitch_seen_reg  <= 1'b0;
            yaw_seen_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            live_reg      <= 1'b1;
            out_valid_reg <= out_valid_next;

            // writes land at once; host must write only with nothing in flight; unenforced
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_idx_t'(cfg_ch.index))
                    CFG_ATT_GAIN:  cfg_reg.attitude_gain <= cfg_ch.data;
                    CFG_RATE_GAIN: cfg_reg.rate_gain     <= cfg_ch.data;
                    CFG_DAMP_GAIN: cfg_reg.damping_gain  <= cfg_ch.data;
                    CFG_YAW_GAIN:  cfg_reg.yaw_gain      <= cfg_ch.data;
                    CFG_IDLE:      cfg_reg.idle_level    <= cfg_ch.data[MOT_W-1:0];
                    CFG_PERIOD:    cfg_reg.loop_period   <= cfg_ch.data;
                    default:       ;
                endcase
            end

            case (state_reg)
                T_IDLE:
                begin
                    if (in_accept)
                    begin
                        // a valid setpoint wins over a hold request
                        if (in_ch.setpoint_valid)
                        begin
                            held_roll_reg   <= in_ch.roll_setpoint;
                            held_pitch_reg  <= in_ch.pitch_setpoint;
                            held_yaw_reg    <= in_ch.yaw_rate_setpoint;
                            held_thrust_reg <= in_ch.thrust_setpoint;
                            hold_reg        <= 1'b0;
                        end
                        else if (in_ch.hold_request)
                        begin
                            hold_reg <= 1'b1;
                        end
                        state_reg <= T_START;
                    end
                end
                T_START:
                begin
                    roll_seen_reg  <= 1'b0;
                    pitch_seen_reg <= 1'b0;
                    yaw_seen_reg   <= 1'b0;
                    state_reg      <= T_RUN;
                end
                T_RUN:
                begin
                    if (roll_done)
                        roll_seen_reg <= 1'b1;
                    if (pitch_done)
                        pitch_seen_reg <= 1'b1;
                    if (yaw_done)
                        yaw_seen_reg <= 1'b1;
                    if (all_done)
                        state_reg <= T_FIN;
                end
                T_FIN:
                begin
                    if (out_free)
                        state_reg <= T_IDLE;
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            gx_reg <= in_ch.gyro_x;
            gy_reg <= in_ch.gyro_y;
            gz_reg <= in_ch.gyro_z;
        end
        if (yaw_done)
            yaw_u_reg <= $signed(yaw_sh[U_W-1:0]);
        if ((state_reg == T_FIN) && out_free)
        begin
            el_reg <= CMD_W'(el_c);
            er_reg <= CMD_W'(er_c);
            ml_reg <= MOT_W'(ml_c);
            mr_reg <= MOT_W'(mr_c);
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.left_elevon  = el_reg;
    assign out_ch.right_elevon = er_reg;
    assign out_ch.motor_left   = ml_reg;
    assign out_ch.motor_right  = mr_reg;

endmodule

// ===== rtl/earc_checker.sv =====
// port-level assertions for the controller and their bind
module earc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [earc_pkg::CMD_W-1:0] left_elevon,
    input  logic signed [earc_pkg::CMD_W-1:0] right_elevon,
    input  logic [earc_pkg::MOT_W-1:0]        motor_left,
    input  logic [earc_pkg::MOT_W-1:0]        motor_right
);
    import earc_pkg::*;

    // one sample in flight: no second accept right behind the first
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a transaction is in flight");

    a_motor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (motor_left <= MOT_W'(ONE_Q)) && (motor_right <= MOT_W'(ONE_Q)))
        else $error("motor command above full thrust");

    a_elevon_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_elevon >= -ONE_Q) && (left_elevon <= ONE_Q) &&
                      (right_elevon >= -ONE_Q) && (right_elevon <= ONE_Q))
        else $error("elevon command out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_elevon) &&
            $stable(right_elevon) && $stable(motor_left) && $stable(motor_right))
        else $error("stalled result changed");

endmodule

bind elevon_attitude_rate_controller earc_checker u_earc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .left_elevon  (out_ch.left_elevon),
    .right_elevon (out_ch.right_elevon),
    .motor_left   (out_ch.motor_left),
    .motor_right  (out_ch.motor_right)
);

// ===== test/tb.sv =====
// testbench for the elevon attitude-rate controller: directed and random samples, self-checking
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import earc_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int DRAIN_LIMIT = 100000;
    localparam int SETTLE      = 80;      // a little over one accept-to-accept interval

    // fixed-point limits of the control law, built from the fraction width, and the estimate rails
    localparam longint UNITY         = longint'(1) <<< FRAC_BITS;
    localparam longint RATE_CMD_LIM  = 2 * UNITY;
    localparam longint YAW_MIX_LIM   = UNITY / 4;
    localparam longint HOLD_SURF_LIM = (3 * UNITY + 5) / 10;
    localparam longint ANGLE_EST_MAX = (longint'(1) <<< 31) - 1;
    localparam longint ANGLE_EST_MIN = -(longint'(1) <<< 31);

    // register indexes past the end of the map, writes there must be dropped
    localparam logic [IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    typedef struct {
        logic                     setpoint_valid;
        logic signed [DATA_W-1:0] roll_setpoint;
        logic signed [DATA_W-1:0] pitch_setpoint;
        logic signed [DATA_W-1:0] yaw_rate_setpoint;
        logic signed [DATA_W-1:0] thrust_setpoint;
        logic signed [DATA_W-1:0] gyro_x;
        logic signed [DATA_W-1:0] gyro_y;
        logic signed [DATA_W-1:0] gyro_z;
        logic                     hold_request;
    } sample_t;

    typedef struct {
        logic signed [CMD_W-1:0] left_elevon;
        logic signed [CMD_W-1:0] right_elevon;
        logic [MOT_W-1:0]        motor_left;
        logic [MOT_W-1:0]        motor_right;
    } surface_cmd_t;

    typedef enum {PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH} pacing_t;

    logic clk = 1'b0;
    logic rst_n;

    earc_in_if  in_ch ();
    earc_out_if out_ch ();
    earc_cfg_if cfg_ch ();

    elevon_attitude_rate_controller dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // controller model state: gains, latched setpoint, hold mode, angle estimates
    longint k_att, k_rate, k_damp, k_yaw, idle_cmd, dt_q16;
    logic signed [DATA_W-1:0] latched_roll, latched_pitch, latched_yaw_rate, latched_thrust;
    logic   holding;
    longint roll_angle_est, pitch_angle_est;

    surface_cmd_t expected_cmds[$];

    int samples_sent;
    int commands_checked;
    int register_writes;
    int fail_count;

    // pacing knobs shared by the sender, the receiver and the test tasks
    int src_idle_pct;
    int snk_stall_pct;
    int long_stall_left;

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int span(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    task automatic reset_model();
        k_att            = longint'(RST_ATT_GAIN);
        k_rate           = longint'(RST_RATE_GAIN);
        k_damp           = longint'(RST_DAMP_GAIN);
        k_yaw            = longint'(RST_YAW_GAIN);
        idle_cmd         = longint'(RST_IDLE);
        dt_q16           = longint'(RST_PERIOD);
        latched_roll     = '0;
        latched_pitch    = '0;
        latched_yaw_rate = '0;
        latched_thrust   = '0;
        holding          = 1'b0;
        roll_angle_est   = 0;
        pitch_angle_est  = 0;
    endtask

    // one control step: latch, error from the old estimate, integrate, cascade, mix
    function automatic surface_cmd_t compute_surface_cmd(input sample_t s);
        longint p, q, r, roll_ang_diff, pitch_ang_diff, roll_cmd, pitch_cmd;
        longint roll_u, pitch_u, yaw_u, yaw_mix, thr, el, er, ml, mr;
        surface_cmd_t c;
        p = s.gyro_x;
        q = s.gyro_y;
        r = s.gyro_z;
        if (s.hold_request)
            holding = 1'b1;
        // a valid setpoint wins over a hold request in the same sample
        if (s.setpoint_valid)
        begin
            latched_roll     = s.roll_setpoint;
            latched_pitch    = s.pitch_setpoint;
            latched_yaw_rate = s.yaw_rate_setpoint;
            latched_thrust   = s.thrust_setpoint;
            holding          = 1'b0;
        end
        roll_ang_diff  = longint'(latched_roll) * 65536 - roll_angle_est;
        pitch_ang_diff = longint'(latched_pitch) * 65536 - pitch_angle_est;
        roll_angle_est  = sat(roll_angle_est + p * dt_q16, ANGLE_EST_MIN, ANGLE_EST_MAX);
        pitch_angle_est = sat(pitch_angle_est + q * dt_q16, ANGLE_EST_MIN, ANGLE_EST_MAX);
        roll_cmd  = sat((k_att * roll_ang_diff) >>> EST_SHIFT, -RATE_CMD_LIM, RATE_CMD_LIM);
        pitch_cmd = sat((k_att * pitch_ang_diff) >>> EST_SHIFT, -RATE_CMD_LIM, RATE_CMD_LIM);
        roll_u  = (k_rate * (roll_cmd - p) - k_damp * p) >>> FRAC_BITS;
        pitch_u = (k_rate * (pitch_cmd - q) - k_damp * q) >>> FRAC_BITS;
        yaw_u   = (k_yaw * (longint'(latched_yaw_rate) - r)) >>> FRAC_BITS;
        el      = sat(pitch_u + roll_u, -UNITY, UNITY);
        er      = sat(pitch_u - roll_u, -UNITY, UNITY);
        yaw_mix = sat(yaw_u, -YAW_MIX_LIM, YAW_MIX_LIM);
        thr     = sat(longint'(latched_thrust), 0, UNITY);
        ml      = sat(thr - yaw_mix, 0, UNITY);
        mr      = sat(thr + yaw_mix, 0, UNITY);
        if (holding)
        begin
            el = sat((-k_rate * p) >>> FRAC_BITS, -HOLD_SURF_LIM, HOLD_SURF_LIM);
            er = sat((-k_rate * q) >>> FRAC_BITS, -HOLD_SURF_LIM, HOLD_SURF_LIM);
            ml = sat(idle_cmd, 0, UNITY);
            mr = ml;
        end
        c.left_elevon  = el[CMD_W-1:0];
        c.right_elevon = er[CMD_W-1:0];
        c.motor_left   = ml[MOT_W-1:0];
        c.motor_right  = mr[MOT_W-1:0];
        return c;
    endfunction

    function automatic sample_t make_sample(input logic sp_valid, input int roll, input int pitch,
                                            input int yaw, input int thrust, input int gx,
                                            input int gy, input int gz, input logic hold);
        sample_t s;
        s.setpoint_valid    = sp_valid;
        s.roll_setpoint     = DATA_W'(roll);
        s.pitch_setpoint    = DATA_W'(pitch);
        s.yaw_rate_setpoint = DATA_W'(yaw);
        s.thrust_setpoint   = DATA_W'(thrust);
        s.gyro_x            = DATA_W'(gx);
        s.gyro_y            = DATA_W'(gy);
        s.gyro_z            = DATA_W'(gz);
        s.hold_request      = hold;
        return s;
    endfunction

    // mostly plausible flight samples so the estimates evolve, some raw noise
    function automatic sample_t random_sample();
        sample_t s;
        if ($urandom_range(99) < 80)
        begin
            s = make_sample($urandom_range(99) < 60, span(-6144, 6144), span(-6144, 6144),
                            span(-8192, 8192), span(-1024, 5120), span(-8192, 8192),
                            span(-8192, 8192), span(-8192, 8192), $urandom_range(99) < 8);
        end
        else
        begin
            s = make_sample($urandom_range(1), $urandom(), $urandom(), $urandom(), $urandom(),
                            $urandom(), $urandom(), $urandom(), $urandom_range(1));
        end
        return s;
    endfunction

    // offer one sample, wait for the transaction, then log its expected commands
    task automatic send_sample(input sample_t s);
        int gap;
        gap = 0;
        while (gap < 200 && $urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.setpoint_valid    <= s.setpoint_valid;
        in_ch.roll_setpoint     <= s.roll_setpoint;
        in_ch.pitch_setpoint    <= s.pitch_setpoint;
        in_ch.yaw_rate_setpoint <= s.yaw_rate_setpoint;
        in_ch.thrust_setpoint   <= s.thrust_setpoint;
        in_ch.gyro_x            <= s.gyro_x;
        in_ch.gyro_y            <= s.gyro_y;
        in_ch.gyro_z            <= s.gyro_z;
        in_ch.hold_request      <= s.hold_request;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_cmds.push_back(compute_surface_cmd(s));
        samples_sent++;
    endtask

    // stop offering and let every outstanding command come back
    task automatic wait_for_commands_drained();
        int waited;
        in_ch.valid <= 1'b0;
        waited = 0;
        while (expected_cmds.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_cmds.size() != 0)
        begin
            $error("%0d surface commands never arrived", expected_cmds.size());
            fail_count++;
        end
        repeat (4) @(posedge clk);
    endtask

    // leaves valid high; the caller drops it after the last write of a group
    task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        register_writes++;
        case (idx)
            CFG_ATT_GAIN:  k_att    = longint'(value);
            CFG_RATE_GAIN: k_rate   = longint'(value);
            CFG_DAMP_GAIN: k_damp   = longint'(value);
            CFG_YAW_GAIN:  k_yaw    = longint'(value);
            CFG_IDLE:      idle_cmd = longint'(value[MOT_W-1:0]);
            CFG_PERIOD:    dt_q16   = longint'(value);
            default:       ;
        endcase
    endtask

    task automatic write_settings(input logic [CFG_W-1:0] att, input logic [CFG_W-1:0] rate,
                                  input logic [CFG_W-1:0] damp, input logic [CFG_W-1:0] yaw,
                                  input logic [CFG_W-1:0] idle, input logic [CFG_W-1:0] period);
        wait_for_commands_drained();
        repeat (SETTLE) @(posedge clk);
        write_register(CFG_ATT_GAIN, att);
        write_register(CFG_RATE_GAIN, rate);
        write_register(CFG_DAMP_GAIN, damp);
        write_register(CFG_YAW_GAIN, yaw);
        write_register(CFG_IDLE, idle);
        write_register(CFG_PERIOD, period);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] random_gain();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return CFG_W'($urandom_range(12288));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_period();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return CFG_W'($urandom());
            default: return CFG_W'($urandom_range(1, 2000));
        endcase
    endfunction

    task automatic set_pacing(input pacing_t mode);
        case (mode)
            PACE_FULL:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            PACE_SRC_IDLE:
            begin
                src_idle_pct  = 71;
                snk_stall_pct = 0;
            end
            PACE_SNK_STALL:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 71;
            end
            PACE_BOTH:
            begin
                src_idle_pct  = 11;
                snk_stall_pct = 11;
            end
            default:        ;
        endcase
    endtask

    // receiver: random stalls, or a long hold-off when a test asks for one
    always @(posedge clk)
    begin
        if (long_stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            long_stall_left--;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // every output transaction is matched against the oldest expected command
    always @(posedge clk)
    begin : check_commands
        surface_cmd_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_cmds.size() == 0)
            begin
                $error("surface command with no sample waiting for it");
                fail_count++;
            end
            else
            begin
                want = expected_cmds.pop_front();
                commands_checked++;
                if (out_ch.left_elevon !== want.left_elevon)
                begin
                    $error("left_elevon expected %0d got %0d",
                           want.left_elevon, out_ch.left_elevon);
                    fail_count++;
                end
                if (out_ch.right_elevon !== want.right_elevon)
                begin
                    $error("right_elevon expected %0d got %0d",
                           want.right_elevon, out_ch.right_elevon);
                    fail_count++;
                end
                if (out_ch.motor_left !== want.motor_left)
                begin
                    $error("motor_left expected %0d got %0d",
                           want.motor_left, out_ch.motor_left);
                    fail_count++;
                end
                if (out_ch.motor_right !== want.motor_right)
                begin
                    $error("motor_right expected %0d got %0d",
                           want.motor_right, out_ch.motor_right);
                    fail_count++;
                end
            end
        end
    end

    // reset gains: field extremes, setpoint reuse, hold mode entry and exit, thrust clamp
    task automatic test_reset_gains();
        set_pacing(PACE_FULL);
        send_sample(make_sample(1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_sample(make_sample(1, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 0));
        send_sample(make_sample(1, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0));
        // invalid setpoint: last latched one stays in use, junk fields ignored
        send_sample(make_sample(0, 12345, -9876, 4321, -5555, 1000, -2000, 3000, 0));
        // hold request alone enters hold, and hold persists with no new setpoint
        send_sample(make_sample(0, 0, 0, 0, 0, 30000, -30000, 500, 1));
        send_sample(make_sample(0, 0, 0, 0, 0, -300, 250, -500, 0));
        // hold request and valid setpoint in one sample: the setpoint wins
        send_sample(make_sample(1, 2048, -2048, 1024, 2048, 400, -400, 100, 1));
        // thrust below zero and above one clamp, yaw mix pushed both ways
        send_sample(make_sample(1, 0, 0, 8192, -4096, 0, 0, -8192, 0));
        send_sample(make_sample(1, 0, 0, -8192, 20000, 0, 0, 8192, 0));
        send_sample(make_sample(1, 1000, -1500, 200, 3000, 120, -80, 40, 0));
    endtask

    // extreme settings: maximum gains, idle above one, unmapped writes, estimate saturation
    task automatic test_extreme_settings();
        write_settings('1, '1, '1, '1, '1, '1);
        write_register(CFG_UNMAPPED_LO, 16'h1234);
        write_register(CFG_UNMAPPED_HI, 16'hFFFF);
        cfg_ch.valid <= 1'b0;
        // hold mode with the idle level saturating to full thrust
        send_sample(make_sample(0, 0, 0, 0, 0, 100, -100, 0, 1));
        // leave hold, drive the estimates into the positive rail, then back into the negative rail
        send_sample(make_sample(1, 4096, -4096, 0, 4096, 32767, 32767, 0, 0));
        send_sample(make_sample(0, 0, 0, 0, 0, 32767, 32767, 0, 0));
        send_sample(make_sample(0, 0, 0, 0, 0, -32768, -32768, 0, 0));
        send_sample(make_sample(0, 0, 0, 0, 0, -32768, -32768, 0, 0));
        send_sample(make_sample(0, 0, 0, 0, 0, -32768, -32768, 0, 0));
        send_sample(make_sample(0, 0, 0, 0, 0, -32768, -32768, 0, 0));
        // all gains and the period at zero, idle exactly one
        write_settings('0, '0, '0, '0, 16'd4096, '0);
        send_sample(make_sample(1, -8000, 8000, 5000, 2048, 9000, -9000, 7000, 0));
        send_sample(make_sample(0, 0, 0, 0, 0, 9000, -9000, 0, 1));
        write_settings(16'd4096, 16'd4096, 16'd0, 16'd4096, 16'd0, 16'd66);
    endtask

    // random samples under each pacing, two random register settings per pacing
    task automatic test_random_pacing();
        pacing_t modes[4];
        modes = '{PACE_FULL, PACE_SRC_IDLE, PACE_SNK_STALL, PACE_BOTH};
        foreach (modes[m])
        begin
            for (int set = 0; set < 2; set++)
            begin
                write_settings(random_gain(), random_gain(), random_gain(), random_gain(),
                               CFG_W'($urandom()), random_period());
                set_pacing(modes[m]);
                for (int n = 0; n < 130; n++)
                    send_sample(random_sample());
            end
        end
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_backpressure();
        wait_for_commands_drained();
        set_pacing(PACE_FULL);
        @(posedge clk);
        long_stall_left = 400;
        for (int n = 0; n < 8; n++)
            send_sample(random_sample());
        // sender then pauses until every command is back before the last burst
        wait_for_commands_drained();
        for (int n = 0; n < 6; n++)
            send_sample(random_sample());
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        in_ch.valid             = 1'b0;
        in_ch.setpoint_valid    = 1'b0;
        in_ch.roll_setpoint     = '0;
        in_ch.pitch_setpoint    = '0;
        in_ch.yaw_rate_setpoint = '0;
        in_ch.thrust_setpoint   = '0;
        in_ch.gyro_x            = '0;
        in_ch.gyro_y            = '0;
        in_ch.gyro_z            = '0;
        in_ch.hold_request      = 1'b0;
        out_ch.ready            = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = '0;
        cfg_ch.data             = '0;
        samples_sent            = 0;
        commands_checked        = 0;
        register_writes         = 0;
        fail_count              = 0;
        long_stall_left         = 0;
        set_pacing(PACE_FULL);
        reset_model();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_gains();
        test_extreme_settings();
        test_output_backpressure();
        test_random_pacing();

        wait_for_commands_drained();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d samples, %0d checked commands, %0d register writes",
                 samples_sent, commands_checked, register_writes);
        $display("pacing: none, idle sender, stalled receiver, both; plus a long output hold-off");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
